@@ rtl/gmcp_pkg.sv @@
// shared types and constants for the greedy mesh chunk planner
// used by every module of the planner; no dependencies

package gmcp_pkg;

  // defaults for the top-level parameters
  localparam int MAX_VERTS_DEF  = 64;
  localparam int MAX_TRIS_DEF   = 128;
  localparam int INDEX_BITS_DEF = 16;
  localparam int FACE_BITS_DEF  = 24;

  // fixed widths of the configuration register and the result fields
  localparam int VCOUNT_W     = 17;
  localparam int FIRST_W      = 24;
  localparam int COUNT_W      = 8;
  localparam int STATUS_W     = 2;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 17'h10000;

  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_AW      = $clog2(OUTQ_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FACE_OVF  = 2'd2
  } status_e;

  typedef struct packed {
    logic [FIRST_W-1:0] first_face;
    logic [COUNT_W-1:0] face_count;
    status_e            status;
    logic               run_end;
  } res_t;

  // up to two result words caused by one face, second only with the first
  typedef struct packed {
    logic valid0;
    logic valid1;
    res_t res0;
    res_t res1;
  } res_pair_t;

endpackage

@@ rtl/gmcp_lane.sv @@
// one membership lane: compares a vertex index against the open chunk's store
// and checks it against the vertex count; depends on gmcp_pkg

module gmcp_lane #(
  parameter int MAX_VERTS  = gmcp_pkg::MAX_VERTS_DEF,
  parameter int INDEX_BITS = gmcp_pkg::INDEX_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0]              vertex_i,
  input  logic [INDEX_BITS-1:0]              store_i [MAX_VERTS],
  input  logic [$clog2(MAX_VERTS+1)-1:0]     set_size_i,
  input  logic [gmcp_pkg::VCOUNT_W-1:0]      vertex_count_i,
  output logic                               hit_o,
  output logic                               bad_o
);
  import gmcp_pkg::*;

  localparam int SW    = $clog2(MAX_VERTS + 1);
  localparam int CMP_W = (INDEX_BITS > VCOUNT_W) ? INDEX_BITS : VCOUNT_W;

  logic [MAX_VERTS-1:0] match;

  always_comb begin
    for (int i = 0; i < MAX_VERTS; i++) begin
      // only entries below the fill level hold chunk vertices
      match[i] = (SW'(i) < set_size_i) && (store_i[i] == vertex_i);
    end
  end

  assign hit_o = |match;
  assign bad_o = CMP_W'(vertex_i) >= CMP_W'(vertex_count_i);

endmodule

@@ rtl/gmcp_merge.sv @@
// merge stage: combines the three lane results into the chunk decision,
// the next chunk state, the store writes and the result words; uses gmcp_pkg

module gmcp_merge #(
  parameter int MAX_VERTS  = gmcp_pkg::MAX_VERTS_DEF,
  parameter int MAX_TRIS   = gmcp_pkg::MAX_TRIS_DEF,
  parameter int INDEX_BITS = gmcp_pkg::INDEX_BITS_DEF,
  parameter int FACE_BITS  = gmcp_pkg::FACE_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0]                 vertex_i [3],
  input  logic [2:0]                            hit_i,
  input  logic [2:0]                            bad_i,
  input  logic                                  final_i,
  input  logic [$clog2(MAX_VERTS+1)-1:0]        set_size_i,
  input  logic [$clog2(MAX_TRIS+1)-1:0]         tri_count_i,
  input  logic [FACE_BITS-1:0]                  chunk_start_i,
  input  logic [FACE_BITS-1:0]                  face_num_i,
  output logic [$clog2(MAX_VERTS+1)-1:0]        set_size_o,
  output logic [$clog2(MAX_TRIS+1)-1:0]         tri_count_o,
  output logic [FACE_BITS-1:0]                  chunk_start_o,
  output logic [FACE_BITS-1:0]                  face_num_o,
  output logic [2:0]                            wr_en_o,
  output logic [$clog2(MAX_VERTS+1)-1:0]        wr_addr_o [3],
  output gmcp_pkg::res_pair_t                   res_o
);
  import gmcp_pkg::*;

  localparam int SW = $clog2(MAX_VERTS + 1);
  localparam int TW = $clog2(MAX_TRIS + 1);
  localparam logic [SW-1:0] MAXV   = SW'(MAX_VERTS);
  localparam logic [SW:0]   MAXV_X = (SW+1)'(MAX_VERTS);
  localparam logic [TW-1:0] MAXT   = TW'(MAX_TRIS);

  logic [2:0]       rep;
  logic [2:0]       keep;
  logic [2:0]       fresh;
  logic [1:0]       adds;
  logic             close;
  logic             err_idx;
  logic             err_ovf;
  logic [SW-1:0]    base;
  logic [TW-1:0]    tri_base;
  logic [FACE_BITS-1:0] start_base;
  logic [TW-1:0]    tri_next;

  always_comb begin
    rep[0] = 1'b0;
    rep[1] = vertex_i[1] == vertex_i[0];
    rep[2] = (vertex_i[2] == vertex_i[0]) || (vertex_i[2] == vertex_i[1]);
    keep   = ~rep & ~hit_i;
    adds   = 2'(keep[0]) + 2'(keep[1]) + 2'(keep[2]);

    close = (tri_count_i != '0) &&
            ((tri_count_i >= MAXT) || (({1'b0, set_size_i} + (SW+1)'(adds)) > MAXV_X));

    // a fresh chunk sees every distinct index of the face as new
    fresh      = close ? ~rep : keep;
    base       = close ? '0 : set_size_i;
    tri_base   = close ? '0 : tri_count_i;
    start_base = close ? face_num_i : chunk_start_i;

    wr_addr_o[0] = base;
    wr_addr_o[1] = base + SW'(fresh[0]);
    wr_addr_o[2] = wr_addr_o[1] + SW'(fresh[1]);
    for (int p = 0; p < 3; p++) begin
      wr_en_o[p] = fresh[p] && (wr_addr_o[p] < MAXV);
    end

    tri_next = tri_base + TW'(1);
    err_idx  = |bad_i;
    err_ovf  = &face_num_i;

    set_size_o    = base + SW'(wr_en_o[0]) + SW'(wr_en_o[1]) + SW'(wr_en_o[2]);
    tri_count_o   = tri_next;
    chunk_start_o = start_base;
    face_num_o    = face_num_i + FACE_BITS'(1);

    res_o.valid0 = 1'b0;
    res_o.valid1 = 1'b0;
    res_o.res0   = '{first_face: FIRST_W'(chunk_start_i), face_count: COUNT_W'(tri_count_i),
                     status: ST_OK, run_end: !final_i};
    res_o.res1   = '{first_face: FIRST_W'(start_base), face_count: COUNT_W'(tri_next),
                     status: ST_OK, run_end: 1'b1};

    if (err_idx || err_ovf) begin
      // the index check wins over the face counter check
      wr_en_o       = '0;
      set_size_o    = '0;
      tri_count_o   = '0;
      chunk_start_o = '0;
      face_num_o    = '0;
      res_o.valid0  = 1'b1;
      res_o.res0    = '{first_face: FIRST_W'(face_num_i), face_count: '0,
                        status: err_idx ? ST_BAD_INDEX : ST_FACE_OVF, run_end: 1'b1};
    end else begin
      if (close) begin
        res_o.valid0 = 1'b1;
        res_o.valid1 = final_i;
      end else if (final_i) begin
        res_o.valid0 = 1'b1;
        res_o.res0   = res_o.res1;
      end
      if (final_i) begin
        set_size_o    = '0;
        tri_count_o   = '0;
        chunk_start_o = '0;
        face_num_o    = '0;
      end
    end
  end

endmodule

@@ rtl/gmcp_outq.sv @@
// result queue: takes up to two result words per cycle and hands them out
// one word per cycle on the master side while the receiver is ready; uses gmcp_pkg

module gmcp_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gmcp_pkg::res_pair_t   push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output gmcp_pkg::res_t        res_o
);
  import gmcp_pkg::*;

  res_t                 mem_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OUTQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OUTQ_AW:0]     count_q, count_d;
  logic                 pop;
  logic [1:0]           n_push;

  assign valid_o = count_q != '0;
  assign res_o   = mem_q[rd_ptr_q];
  // room for the two words one face may cause
  assign room_o  = count_q <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2);
  assign pop     = valid_o && ready_i;
  assign n_push  = 2'(push_i.valid0) + 2'(push_i.valid1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUTQ_AW'(n_push);
    rd_ptr_d = rd_ptr_q + OUTQ_AW'(pop);
    count_d  = count_q + (OUTQ_AW+1)'(n_push) - (OUTQ_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.valid1) begin
      mem_q[wr_ptr_q + OUTQ_AW'(1)] <= push_i.res1;
    end
  end

endmodule

@@ rtl/greedy_mesh_chunk_planner_core.sv @@
// top level of the greedy mesh chunk planner: vertex store, chunk state,
// three membership lanes, merge stage and result queue; uses gmcp_pkg,
// gmcp_lane, gmcp_merge and gmcp_outq

// Usage
// - slave side takes one triangle per word: tdata holds vertex_a, vertex_b,
//   vertex_c from the low bits up, tlast marks the last face of the model
// - master side gives result words: tdata holds chunk_first_face then
//   chunk_face_count, tuser the status, tlast marks the last word of a face
// - cfg_we_i/cfg_wdata_i write vertex_count; write only while the block idles
// - one face is taken every cycle while the queue has room: the three lanes
//   check the indices against the vertex store in parallel, the chunk state
//   updates in that cycle and its result words are written into the queue;
//   a face that closes a chunk and is final gives two words
// - a four-word queue holds results; s_axis_tready drops while fewer than two
//   slots are free, so a stalled receiver stalls the input once three words wait
// - reset empties the queue and the open chunk and sets vertex_count to 65536;
//   the vertex store itself is not cleared, its fill level tracks valid entries

module greedy_mesh_chunk_planner_core #(
  parameter int MAX_VERTS  = gmcp_pkg::MAX_VERTS_DEF,
  parameter int MAX_TRIS   = gmcp_pkg::MAX_TRIS_DEF,
  parameter int INDEX_BITS = gmcp_pkg::INDEX_BITS_DEF,
  parameter int FACE_BITS  = gmcp_pkg::FACE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [gmcp_pkg::VCOUNT_W-1:0]          cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // vertex_a, vertex_b, vertex_c from bit 0 up, zero padded to bytes
  input  logic [((3*INDEX_BITS+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // chunk_first_face [23:0], chunk_face_count [31:24]
  output logic [gmcp_pkg::FIRST_W+gmcp_pkg::COUNT_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [gmcp_pkg::STATUS_W-1:0]          m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import gmcp_pkg::*;

  localparam int SW = $clog2(MAX_VERTS + 1);
  localparam int TW = $clog2(MAX_TRIS + 1);

  logic [VCOUNT_W-1:0]   vcount_q;
  logic [INDEX_BITS-1:0] store_q [MAX_VERTS];
  logic [SW-1:0]         set_size_q, set_size_d;
  logic [TW-1:0]         tri_count_q, tri_count_d;
  logic [FACE_BITS-1:0]  chunk_start_q, chunk_start_d;
  logic [FACE_BITS-1:0]  face_num_q, face_num_d;

  logic [INDEX_BITS-1:0] vertex [3];
  logic [2:0]            hit;
  logic [2:0]            bad;
  logic [2:0]            wr_en;
  logic [SW-1:0]         wr_addr [3];
  logic                  accept;
  logic                  room;
  res_pair_t             merged;
  res_pair_t             push;
  res_t                  head;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room;

  for (genvar p = 0; p < 3; p++) begin : g_lane
    assign vertex[p] = s_axis_tdata[p*INDEX_BITS +: INDEX_BITS];

    gmcp_lane #(
      .MAX_VERTS  (MAX_VERTS),
      .INDEX_BITS (INDEX_BITS)
    ) u_lane (
      .vertex_i       (vertex[p]),
      .store_i        (store_q),
      .set_size_i     (set_size_q),
      .vertex_count_i (vcount_q),
      .hit_o          (hit[p]),
      .bad_o          (bad[p])
    );
  end

  gmcp_merge #(
    .MAX_VERTS  (MAX_VERTS),
    .MAX_TRIS   (MAX_TRIS),
    .INDEX_BITS (INDEX_BITS),
    .FACE_BITS  (FACE_BITS)
  ) u_merge (
    .vertex_i      (vertex),
    .hit_i         (hit),
    .bad_i         (bad),
    .final_i       (s_axis_tlast),
    .set_size_i    (set_size_q),
    .tri_count_i   (tri_count_q),
    .chunk_start_i (chunk_start_q),
    .face_num_i    (face_num_q),
    .set_size_o    (set_size_d),
    .tri_count_o   (tri_count_d),
    .chunk_start_o (chunk_start_d),
    .face_num_o    (face_num_d),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .res_o         (merged)
  );

  always_comb begin
    push        = merged;
    push.valid0 = merged.valid0 && accept;
    push.valid1 = merged.valid1 && accept;
  end

  gmcp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (head)
  );

  assign m_axis_tdata = {head.face_count, head.first_face};
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.run_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q      <= VCOUNT_RST;
      set_size_q    <= '0;
      tri_count_q   <= '0;
      chunk_start_q <= '0;
      face_num_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      if (accept) begin
        set_size_q    <= set_size_d;
        tri_count_q   <= tri_count_d;
        chunk_start_q <= chunk_start_d;
        face_num_q    <= face_num_d;
      end
    end
  end

  // vertex store, up to three distinct entries appended per face
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_VERTS; i++) begin
      if (accept && wr_en[0] && (wr_addr[0] == SW'(i))) begin
        store_q[i] <= vertex[0];
      end else if (accept && wr_en[1] && (wr_addr[1] == SW'(i))) begin
        store_q[i] <= vertex[1];
      end else if (accept && wr_en[2] && (wr_addr[2] == SW'(i))) begin
        store_q[i] <= vertex[2];
      end
    end
  end

endmodule

@@ bench/greedy_mesh_chunk_planner_core_test.sv @@
// self-checking bench for greedy_mesh_chunk_planner_core: directed faces, then random models
// under several vertex_count settings; needs gmcp_pkg and the planner rtl

`timescale 1ns / 1ps

module greedy_mesh_chunk_planner_core_test;
  import gmcp_pkg::*;

  localparam int MAX_VERTS   = MAX_VERTS_DEF;
  localparam int MAX_TRIS    = MAX_TRIS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYC   = 8;

  typedef struct packed {
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic        final_face;
  } face_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [VCOUNT_W-1:0]         cfg_wdata_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [47:0]                 s_axis_tdata = '0;
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [FIRST_W+COUNT_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]         m_axis_tuser;
  logic                        m_axis_tlast;

  greedy_mesh_chunk_planner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // planner state as the bench sees it
  logic [VCOUNT_W-1:0] vcount = VCOUNT_RST;
  logic [15:0]         vset [MAX_VERTS];
  int                  vset_n = 0;
  int                  tri_n = 0;
  logic [FIRST_W-1:0]  chunk_first = '0;
  logic [FIRST_W-1:0]  face_no = '0;

  face_t face_queue[$];
  res_t  pending_ranges[$];
  face_t offered;

  int cycle_cnt = 0;
  int faces_in = 0;
  int words_out = 0;
  int mismatch_cnt = 0;
  int n_close = 0;
  int n_close_final = 0;
  int n_reject = 0;
  int n_settings = 0;
  int stall_left = 0;
  bit long_stall_done = 1'b0;
  bit calm;

  assign calm = (cycle_cnt >= 3000) && (cycle_cnt < 5000);

  task automatic expect_range(input logic [FIRST_W-1:0] first, input int count,
                              input status_e st, input logic last);
    res_t r;
    r.first_face = first;
    r.face_count = 8'(count);
    r.status     = st;
    r.run_end    = last;
    pending_ranges = {pending_ranges, r};
  endtask

  task automatic restart_model();
    vset_n      = 0;
    tri_n       = 0;
    chunk_first = '0;
    face_no     = '0;
  endtask

  task automatic plan_face(input face_t f);
    logic [15:0] v [3];
    bit          fresh [3];
    bit          rep;
    bit          hit;
    int          adds;
    v[0] = f.vertex_a;
    v[1] = f.vertex_b;
    v[2] = f.vertex_c;
    if ({1'b0, v[0]} >= vcount || {1'b0, v[1]} >= vcount || {1'b0, v[2]} >= vcount) begin
      expect_range(face_no, 0, ST_BAD_INDEX, 1'b1);
      n_reject++;
      restart_model();
      return;
    end
    if (face_no == '1) begin
      expect_range(face_no, 0, ST_FACE_OVF, 1'b1);
      restart_model();
      return;
    end
    adds = 0;
    for (int p = 0; p < 3; p++) begin
      rep = 1'b0;
      hit = 1'b0;
      for (int q = 0; q < p; q++) if (v[q] == v[p]) rep = 1'b1;
      for (int i = 0; i < vset_n; i++) if (vset[i] == v[p]) hit = 1'b1;
      fresh[p] = !rep && !hit;
      if (fresh[p]) adds++;
    end
    // close when either limit would be passed, never on an empty chunk
    if (tri_n != 0 && (tri_n >= MAX_TRIS || vset_n + adds > MAX_VERTS)) begin
      expect_range(chunk_first, tri_n, ST_OK, !f.final_face);
      n_close++;
      if (f.final_face) n_close_final++;
      chunk_first = face_no;
      vset_n      = 0;
      tri_n       = 0;
      for (int p = 0; p < 3; p++) begin
        rep = 1'b0;
        for (int q = 0; q < p; q++) if (v[q] == v[p]) rep = 1'b1;
        fresh[p] = !rep;
      end
    end
    for (int p = 0; p < 3; p++) begin
      if (fresh[p] && vset_n < MAX_VERTS) begin
        vset[vset_n] = v[p];
        vset_n++;
      end
    end
    tri_n++;
    face_no = face_no + 1'b1;
    if (f.final_face) begin
      expect_range(chunk_first, tri_n, ST_OK, 1'b1);
      restart_model();
    end
  endtask

  // driver: takes faces from face_queue, predicts each one when it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        plan_face(offered);
        faces_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (face_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
          offered = face_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {offered.vertex_c, offered.vertex_b, offered.vertex_a};
          s_axis_tlast  <= offered.final_face;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word against the oldest predicted range
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (pending_ranges.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected word: first %0d count %0d status %0d last %0d",
                     m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tuser, m_axis_tlast);
        end else begin
          want = pending_ranges.pop_front();
          if (m_axis_tdata[23:0] !== want.first_face || m_axis_tdata[31:24] !== want.face_count ||
              m_axis_tuser !== want.status || m_axis_tlast !== want.run_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("word %0d: expected first %0d count %0d status %0d last %0d, got %0d %0d %0d %0d",
                       words_out, want.first_face, want.face_count, want.status, want.run_end,
                       m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tuser, m_axis_tlast);
          end
        end
      end
    end
  end

  // receiver: one long hold-off so the result queue fills and the input stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_stall_done && faces_in >= 600) begin
        long_stall_done = 1'b1;
        stall_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d faces queued and %0d words expected",
               face_queue.size(), pending_ranges.size());
      $display("greedy_mesh_chunk_planner_core regression: fail");
      $finish;
    end
  end

  task automatic add_face(input int a, input int b, input int c, input bit fin);
    face_t f;
    f.vertex_a   = 16'(a);
    f.vertex_b   = 16'(b);
    f.vertex_c   = 16'(c);
    f.final_face = fin;
    face_queue = {face_queue, f};
  endtask

  // sender holds off until every word is back and the pipe has drained
  task automatic settle();
    do @(negedge clk_i);
    while (face_queue.size() != 0 || s_axis_tvalid || pending_ranges.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_vcount(input logic [VCOUNT_W-1:0] value);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    vcount = value;
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_index(input int base, input int pool, input int span);
    if (span == 0) return $urandom_range(0, 65535);
    return (base + $urandom_range(0, pool - 1)) % span;
  endfunction

  // random models: small pools reach the triangle limit, wide pools the vertex limit
  task automatic fill_models(input int target);
    int made;
    int len;
    int pool;
    int base;
    int span;
    face_t f;
    made = 0;
    span = (vcount > 17'h10000) ? 65536 : int'(vcount);
    while (made < target) begin
      len = $urandom_range(1, 300);
      case ($urandom_range(0, 3))
        0:       pool = $urandom_range(3, 24);
        1:       pool = $urandom_range(100, 4000);
        2:       pool = $urandom_range(30, 90);
        default: pool = 65536;
      endcase
      base = $urandom_range(0, 65535);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 6) begin
          f.vertex_a   = 16'($urandom_range(0, 65535));
          f.vertex_b   = 16'($urandom_range(0, 65535));
          f.vertex_c   = 16'($urandom_range(0, 65535));
          f.final_face = ($urandom_range(0, 19) == 0);
        end else begin
          f.vertex_a   = 16'(pick_index(base, pool, span));
          f.vertex_b   = 16'(pick_index(base, pool, span));
          f.vertex_c   = 16'(pick_index(base, pool, span));
          f.final_face = (k == len - 1);
          if (span < 65536 && $urandom_range(0, 199) == 0)
            f.vertex_c = 16'($urandom_range(span, 65535));
        end
        face_queue = {face_queue, f};
        made++;
      end
    end
  endtask

  initial begin
    logic [VCOUNT_W-1:0] settings [7];
    int targets [7];
    settings = '{17'h1FFFF, 17'd100, 17'd70, 17'd1, 17'd5000, 17'd3, 17'h10000};
    targets  = '{300, 300, 300, 60, 300, 100, 300};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single final face at index zero, top indices, repeats inside a face
    add_face(0, 0, 0, 1);
    add_face(65535, 65535, 65534, 0);
    for (int k = 1; k <= 20; k++) add_face(3 * k, 3 * k + 1, 3 * k + 2, 0);
    add_face(100, 101, 101, 0);
    // this one passes the vertex limit and is final: close and final together
    add_face(200, 201, 200, 1);
    write_vcount(17'd0);
    add_face(0, 0, 0, 1);
    write_vcount(17'd1);
    add_face(0, 0, 0, 1);
    add_face(0, 1, 0, 0);
    add_face(0, 0, 0, 0);
    add_face(1, 0, 0, 1);

    for (int ph = 0; ph < 7; ph++) begin
      write_vcount(settings[ph]);
      fill_models(targets[ph]);
    end

    settle();
    repeat (20) @(negedge clk_i);
    if (pending_ranges.size() != 0) begin
      mismatch_cnt += pending_ranges.size();
      $display("%0d expected words never arrived", pending_ranges.size());
    end
    $display("ran %0d faces and %0d result words over %0d vertex_count settings",
             faces_in, words_out, n_settings);
    $display("chunk closes %0d (with final face %0d), rejected faces %0d, mismatches %0d",
             n_close, n_close_final, n_reject, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("greedy_mesh_chunk_planner_core regression: pass");
    end else begin
      $display("greedy_mesh_chunk_planner_core regression: fail");
    end
    $finish;
  end

endmodule
